>>> rtl/msc_pkg.sv
package msc_pkg;

    // fixed field widths
    localparam int WEIGHT_W    = 16;
    localparam int SHIFT_W     = 9;
    localparam int CFG_W       = 8;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;

    // defaults and queue sizing
    localparam int DEF_MAX_DIM = 128;
    localparam int Q_DEPTH     = 4;

    // queue status between the queue and its users
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // largest usable window side: the 8-bit registers cap it at 255
    function automatic int eff_max(input int max_dim);
        return (max_dim > 255) ? 255 : max_dim;
    endfunction

    // bits of a row or column index
    function automatic int idx_w(input int max_dim);
        return $clog2(eff_max(max_dim));
    endfunction

    // bits of a clamped width or height
    function automatic int dim_w(input int max_dim);
        return $clog2(eff_max(max_dim) + 1);
    endfunction

    // bits of a signed offset 2i-(h-1)
    function automatic int d_w(input int max_dim);
        return dim_w(max_dim) + 2;
    endfunction

    // bits of one queue entry: last flag, masked weight, two offsets
    function automatic int ent_w(input int max_dim);
        return 1 + WEIGHT_W + 2 * d_w(max_dim);
    endfunction

    // bits of the weight sum
    function automatic int t_w(input int max_dim);
        return WEIGHT_W + 2 * idx_w(max_dim);
    endfunction

    // bits of a signed moment sum
    function automatic int m_w(input int max_dim);
        return 20 + 3 * idx_w(max_dim);
    endfunction

endpackage

>>> rtl/msc_fifo.sv
module msc_fifo #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = msc_pkg::Q_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [DATA_W-1:0]    wr_data,
    input  logic                 rd_en,
    output logic [DATA_W-1:0]    rd_data,
    output msc_pkg::q_stat_t     stat
);
    import msc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_wr;
    logic              do_rd;

    // status and gated strobes
    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_wr      = wr_en && !stat.full;
    assign do_rd      = rd_en && !stat.empty;
    assign rd_data    = mem_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

>>> rtl/msc_front.sv
module msc_front #(
    parameter int MAX_DIM = msc_pkg::DEF_MAX_DIM
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  clr,
    input  logic [msc_pkg::CFG_W-1:0]             region_width,
    input  logic [msc_pkg::CFG_W-1:0]             region_height,
    input  logic                                  push,
    input  logic [msc_pkg::WEIGHT_W-1:0]          pixel_weight,
    output logic                                  full,
    input  msc_pkg::q_stat_t                      q_stat,
    output logic                                  q_wr,
    output logic [msc_pkg::ent_w(MAX_DIM)-1:0]    q_wdata
);
    import msc_pkg::*;

    localparam int EFF   = eff_max(MAX_DIM);
    localparam int IDX_W = idx_w(MAX_DIM);
    localparam int DIM_W = dim_w(MAX_DIM);
    localparam int D_W   = d_w(MAX_DIM);

    logic [IDX_W-1:0]        col_reg, col_next;
    logic [IDX_W-1:0]        row_reg, row_next;
    logic [DIM_W-1:0]        w_eff, h_eff, hm1;
    logic                    accept;
    logic                    col_end, row_end, last;
    logic signed [D_W-1:0]   dx, dy;
    logic signed [2*D_W-1:0] sqx, sqy;
    logic [2*D_W:0]          r2;
    logic [2*DIM_W-1:0]      hsq;
    logic                    in_disc;
    logic [WEIGHT_W-1:0]     wm;

    // clamp window dimensions
    always_comb
    begin
        if (region_width == '0)
        begin
            w_eff = DIM_W'(1);
        end
        else if (int'(region_width) > EFF)
        begin
            w_eff = DIM_W'(EFF);
        end
        else
        begin
            w_eff = DIM_W'(region_width);
        end
        if (int'(region_height) < 2)
        begin
            h_eff = DIM_W'(2);
        end
        else if (int'(region_height) > EFF)
        begin
            h_eff = DIM_W'(EFF);
        end
        else
        begin
            h_eff = DIM_W'(region_height);
        end
    end

    assign hm1     = h_eff - DIM_W'(1);
    assign accept  = push && !q_stat.full;
    assign full    = q_stat.full;
    assign col_end = (DIM_W'(col_reg) + DIM_W'(1)) >= w_eff;
    assign row_end = (DIM_W'(row_reg) + DIM_W'(1)) >= h_eff;
    assign last    = col_end && row_end;

    // offsets from the height-based centre, doubled
    assign dx = $signed(D_W'({col_reg, 1'b0})) - $signed(D_W'(hm1));
    assign dy = $signed(D_W'({row_reg, 1'b0})) - $signed(D_W'(hm1));

    // disc test
    assign sqx     = dx * dx;
    assign sqy     = dy * dy;
    assign hsq     = hm1 * hm1;
    assign r2      = (2*D_W+1)'($unsigned(sqx)) + (2*D_W+1)'($unsigned(sqy));
    assign in_disc = r2 <= (2*D_W+1)'(hsq);
    assign wm      = in_disc ? pixel_weight : '0;

    assign q_wr    = accept;
    assign q_wdata = {last, wm, dx, dy};

    // raster counters
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (clr)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (col_end)
            begin
                col_next = '0;
                row_next = row_end ? '0 : row_reg + IDX_W'(1);
            end
            else
            begin
                col_next = col_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

>>> rtl/msc_back.sv
module msc_back #(
    parameter int MAX_DIM = msc_pkg::DEF_MAX_DIM
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      clr,
    input  msc_pkg::q_stat_t                          q_stat,
    input  logic [msc_pkg::ent_w(MAX_DIM)-1:0]        q_rdata,
    output logic                                      q_rd,
    input  logic                                      div_rdy,
    output logic                                      div_start,
    output logic signed [msc_pkg::m_w(MAX_DIM)-1:0]   div_mx,
    output logic signed [msc_pkg::m_w(MAX_DIM)-1:0]   div_my,
    output logic [msc_pkg::t_w(MAX_DIM)-1:0]          div_tot
);
    import msc_pkg::*;

    localparam int D_W   = d_w(MAX_DIM);
    localparam int ENT_W = ent_w(MAX_DIM);
    localparam int T_W   = t_w(MAX_DIM);
    localparam int M_W   = m_w(MAX_DIM);

    logic                         ent_last;
    logic [WEIGHT_W-1:0]          ent_wgt;
    logic signed [D_W-1:0]        ent_dx, ent_dy;
    logic signed [D_W+WEIGHT_W:0] px, py;
    logic signed [M_W-1:0]        mx_reg, mx_next, mx_sum;
    logic signed [M_W-1:0]        my_reg, my_next, my_sum;
    logic [T_W-1:0]               tot_reg, tot_next, tot_sum;

    // unpack queue entry
    assign ent_last = q_rdata[ENT_W-1];
    assign ent_wgt  = q_rdata[ENT_W-2 -: WEIGHT_W];
    assign ent_dx   = $signed(q_rdata[2*D_W-1 -: D_W]);
    assign ent_dy   = $signed(q_rdata[D_W-1:0]);

    // window end waits for the divider
    assign q_rd      = !q_stat.empty && (!ent_last || div_rdy);
    assign div_start = q_rd && ent_last;

    // weighted contributions
    assign px      = ent_dx * $signed({1'b0, ent_wgt});
    assign py      = ent_dy * $signed({1'b0, ent_wgt});
    assign mx_sum  = mx_reg + M_W'(px);
    assign my_sum  = my_reg + M_W'(py);
    assign tot_sum = tot_reg + T_W'(ent_wgt);

    assign div_mx  = mx_sum;
    assign div_my  = my_sum;
    assign div_tot = tot_sum;

    // accumulators, cleared at window end or on clr
    always_comb
    begin
        mx_next  = mx_reg;
        my_next  = my_reg;
        tot_next = tot_reg;
        if (clr || (q_rd && ent_last))
        begin
            mx_next  = '0;
            my_next  = '0;
            tot_next = '0;
        end
        else if (q_rd)
        begin
            mx_next  = mx_sum;
            my_next  = my_sum;
            tot_next = tot_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mx_reg  <= '0;
            my_reg  <= '0;
            tot_reg <= '0;
        end
        else
        begin
            mx_reg  <= mx_next;
            my_reg  <= my_next;
            tot_reg <= tot_next;
        end
    end

endmodule

>>> rtl/msc_div.sv
module msc_div #(
    parameter int MAX_DIM = msc_pkg::DEF_MAX_DIM
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      start,
    input  logic signed [msc_pkg::m_w(MAX_DIM)-1:0]   mx,
    input  logic signed [msc_pkg::m_w(MAX_DIM)-1:0]   my,
    input  logic [msc_pkg::t_w(MAX_DIM)-1:0]          tot,
    output logic                                      rdy,
    input  logic                                      out_pop,
    output logic                                      out_valid,
    output logic signed [msc_pkg::SHIFT_W-1:0]        shift_x,
    output logic signed [msc_pkg::SHIFT_W-1:0]        shift_y,
    output logic                                      converged,
    output logic                                      empty_weight
);
    import msc_pkg::*;

    localparam int M_W   = m_w(MAX_DIM);
    localparam int Q_W   = idx_w(MAX_DIM);
    localparam int CNT_W = (Q_W > 1) ? $clog2(Q_W) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]                state_reg, state_next;
    logic                      lane_reg, lane_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [M_W-1:0]            rem_reg, rem_next;
    logic [M_W-1:0]            dsh_reg, dsh_next;
    logic [M_W-1:0]            dbase_reg, dbase_next;
    logic [M_W-1:0]            magy_reg, magy_next;
    logic [Q_W-1:0]            q_reg, q_next;
    logic [Q_W-1:0]            qx_reg, qx_next;
    logic                      negx_reg, negx_next;
    logic                      negy_reg, negy_next;
    logic                      zero_reg, zero_next;
    logic                      ov_reg, ov_next;
    logic signed [SHIFT_W-1:0] sx_reg, sx_next;
    logic signed [SHIFT_W-1:0] sy_reg, sy_next;
    logic                      cv_reg, cv_next;
    logic                      ew_reg, ew_next;
    logic                      ge;
    logic [Q_W-1:0]            q_step;
    logic signed [SHIFT_W-1:0] sx_val, sy_val;

    assign rdy          = (state_reg == ST_IDLE);
    assign out_valid    = ov_reg;
    assign shift_x      = sx_reg;
    assign shift_y      = sy_reg;
    assign converged    = cv_reg;
    assign empty_weight = ew_reg;

    // one restoring step
    assign ge     = rem_reg >= dsh_reg;
    assign q_step = (q_reg << 1) | Q_W'(ge);

    // signed results from magnitudes
    assign sx_val = negx_reg ? -$signed(SHIFT_W'(qx_reg)) : $signed(SHIFT_W'(qx_reg));
    assign sy_val = negy_reg ? -$signed(SHIFT_W'(q_reg)) : $signed(SHIFT_W'(q_reg));

    // sequencer: x lane, then y lane, then hand off; a zero weight sum goes straight to hand off
    always_comb
    begin
        state_next = state_reg;
        lane_next  = lane_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        dsh_next   = dsh_reg;
        dbase_next = dbase_reg;
        magy_next  = magy_reg;
        q_next     = q_reg;
        qx_next    = qx_reg;
        negx_next  = negx_reg;
        negy_next  = negy_reg;
        zero_next  = zero_reg;
        ov_next    = ov_reg;
        sx_next    = sx_reg;
        sy_next    = sy_reg;
        cv_next    = cv_reg;
        ew_next    = ew_reg;
        if (out_pop && ov_reg)
        begin
            ov_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    zero_next  = (tot == '0);
                    dbase_next = M_W'({tot, 1'b0}) << (Q_W - 1);
                    dsh_next   = M_W'({tot, 1'b0}) << (Q_W - 1);
                    negx_next  = mx[M_W-1];
                    negy_next  = my[M_W-1];
                    rem_next   = mx[M_W-1] ? $unsigned(-mx) : $unsigned(mx);
                    magy_next  = my[M_W-1] ? $unsigned(-my) : $unsigned(my);
                    q_next     = '0;
                    qx_next    = '0;
                    lane_next  = 1'b0;
                    cnt_next   = CNT_W'(Q_W - 1);
                    state_next = (tot == '0) ? ST_FIN : ST_RUN;
                end
            end
            ST_RUN:
            begin
                rem_next = ge ? rem_reg - dsh_reg : rem_reg;
                dsh_next = dsh_reg >> 1;
                q_next   = q_step;
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    if (!lane_reg)
                    begin
                        qx_next   = q_step;
                        q_next    = '0;
                        rem_next  = magy_reg;
                        dsh_next  = dbase_reg;
                        lane_next = 1'b1;
                        cnt_next  = CNT_W'(Q_W - 1);
                    end
                    else
                    begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_FIN:
            begin
                if (!ov_reg)
                begin
                    ov_next    = 1'b1;
                    ew_next    = zero_reg;
                    sx_next    = zero_reg ? '0 : sx_val;
                    sy_next    = zero_reg ? '0 : sy_val;
                    cv_next    = zero_reg || ((qx_reg == '0) && (q_reg == '0));
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        lane_reg  <= lane_next;
        cnt_reg   <= cnt_next;
        rem_reg   <= rem_next;
        dsh_reg   <= dsh_next;
        dbase_reg <= dbase_next;
        magy_reg  <= magy_next;
        q_reg     <= q_next;
        qx_reg    <= qx_next;
        negx_reg  <= negx_next;
        negy_reg  <= negy_next;
        zero_reg  <= zero_next;
        sx_reg    <= sx_next;
        sy_reg    <= sy_next;
        cv_reg    <= cv_next;
        ew_reg    <= ew_next;
    end

`ifndef ASSERT_OFF
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> state_reg == ST_IDLE)
        else $error("divider started while busy");

    a_run_no_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN |=> state_reg == ST_RUN || state_reg == ST_FIN)
        else $error("divider left run without finishing");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && ew_reg |-> sx_reg == '0 && sy_reg == '0 && cv_reg)
        else $error("empty weight with nonzero shift");

    a_conv_match: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg |-> cv_reg == (sx_reg == '0 && sy_reg == '0))
        else $error("converged flag disagrees with shifts");
`endif

endmodule

>>> rtl/mean_shift_centroid_step.sv
// Mean-shift centroid step: pixel weights stream in raster order over a window of
// region_width by region_height, one transaction per cycle while full is low; each
// pixel inside the disc centred at (h-1)/2 on both axes adds to the weight and moment
// sums, and the last pixel of a window produces one result with the truncated shifts,
// a converged flag and an empty-weight flag. The front end classifies a pixel in the
// cycle it is taken and places it in a four-entry queue; the back end accumulates one
// entry per cycle while the queue holds entries and the window-end entry is not held
// back. At window end the sums go to a restoring divider that works the x lane, then the
// y lane (both skipped for a zero weight sum), then loads the result register and can
// then take the next window; it runs while the next window accumulates. The window-end
// entry waits in the queue while the previous division is still running or is holding
// its finished result because the result before it has not yet been popped. Writing
// either register restarts the window and must happen while the block is idle.
module mean_shift_centroid_step #(
    parameter int MAX_DIM = msc_pkg::DEF_MAX_DIM
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [msc_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [msc_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [msc_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready,
    input  logic                                push,
    output logic                                full,
    input  logic [msc_pkg::WEIGHT_W-1:0]        pixel_weight,
    output logic                                empty,
    input  logic                                pop,
    output logic signed [msc_pkg::SHIFT_W-1:0]  shift_x,
    output logic signed [msc_pkg::SHIFT_W-1:0]  shift_y,
    output logic                                converged,
    output logic                                empty_weight
);
    import msc_pkg::*;

    localparam int ENT_W = ent_w(MAX_DIM);
    localparam int T_W   = t_w(MAX_DIM);
    localparam int M_W   = m_w(MAX_DIM);

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    logic [CFG_W-1:0]      width_reg, width_next;
    logic [CFG_W-1:0]      height_reg, height_next;
    logic                  cfg_wr;
    logic                  q_wr, q_rd;
    logic [ENT_W-1:0]      q_wdata, q_rdata;
    q_stat_t               q_stat;
    logic                  div_rdy, div_start, out_valid;
    logic signed [M_W-1:0] div_mx, div_my;
    logic [T_W-1:0]        div_tot;

    // register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_HEIGHT) ? APB_DATA_W'(height_reg)
                                             : APB_DATA_W'(width_reg);

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_wr)
        begin
            case (paddr[2])
                REG_WIDTH:  width_next  = pwdata[CFG_W-1:0];
                REG_HEIGHT: height_next = pwdata[CFG_W-1:0];
                default:    width_next  = width_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CFG_W'(1);
            height_reg <= CFG_W'(2);
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    // classify pixels
    msc_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .clr           (cfg_wr),
        .region_width  (width_reg),
        .region_height (height_reg),
        .push          (push),
        .pixel_weight  (pixel_weight),
        .full          (full),
        .q_stat        (q_stat),
        .q_wr          (q_wr),
        .q_wdata       (q_wdata)
    );

    // decoupling queue
    msc_fifo #(
        .DATA_W (ENT_W),
        .DEPTH  (Q_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr),
        .wr_data (q_wdata),
        .rd_en   (q_rd),
        .rd_data (q_rdata),
        .stat    (q_stat)
    );

    // accumulate sums
    msc_back #(
        .MAX_DIM (MAX_DIM)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .clr       (cfg_wr),
        .q_stat    (q_stat),
        .q_rdata   (q_rdata),
        .q_rd      (q_rd),
        .div_rdy   (div_rdy),
        .div_start (div_start),
        .div_mx    (div_mx),
        .div_my    (div_my),
        .div_tot   (div_tot)
    );

    // shift division and result register
    msc_div #(
        .MAX_DIM (MAX_DIM)
    ) u_div (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (div_start),
        .mx           (div_mx),
        .my           (div_my),
        .tot          (div_tot),
        .rdy          (div_rdy),
        .out_pop      (pop),
        .out_valid    (out_valid),
        .shift_x      (shift_x),
        .shift_y      (shift_y),
        .converged    (converged),
        .empty_weight (empty_weight)
    );

    assign empty = !out_valid;

endmodule
